// ===== hw/rtl/atci_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and step table for the ATA task-file command issuer.
package atci_pkg;

    localparam int DRIVE_COUNT_DEFAULT = 4;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    // drive_index is two bits wide, so at most four drives can be named
    localparam int DRIVE_SLOTS = 4;

    // configuration register indexes
    localparam logic [2:0] CFG_CHANNEL_MASK = 3'd0;
    localparam logic [2:0] CFG_SLAVE_MASK   = 3'd1;
    localparam logic [2:0] CFG_LBA28_MASK   = 3'd2;
    localparam logic [2:0] CFG_PRI_CMD_BASE = 3'd3;
    localparam logic [2:0] CFG_PRI_CTL_BASE = 3'd4;
    localparam logic [2:0] CFG_SEC_CMD_BASE = 3'd5;
    localparam logic [2:0] CFG_SEC_CTL_BASE = 3'd6;

    localparam logic [3:0]  CHANNEL_MASK_RESET = 4'd12;
    localparam logic [3:0]  SLAVE_MASK_RESET   = 4'd10;
    localparam logic [3:0]  LBA28_MASK_RESET   = 4'd15;
    localparam logic [15:0] PRI_CMD_BASE_RESET = 16'h01F0;
    localparam logic [15:0] PRI_CTL_BASE_RESET = 16'h03F4;
    localparam logic [15:0] SEC_CMD_BASE_RESET = 16'h0170;
    localparam logic [15:0] SEC_CTL_BASE_RESET = 16'h0374;

    // task-file register numbers
    localparam logic [3:0] REG_SECCOUNT0 = 4'h2;
    localparam logic [3:0] REG_LBA0      = 4'h3;
    localparam logic [3:0] REG_LBA1      = 4'h4;
    localparam logic [3:0] REG_LBA2      = 4'h5;
    localparam logic [3:0] REG_DEVSEL    = 4'h6;
    localparam logic [3:0] REG_COMMAND   = 4'h7;
    localparam logic [3:0] REG_SECCOUNT1 = 4'h8;
    localparam logic [3:0] REG_LBA3      = 4'h9;
    localparam logic [3:0] REG_LBA4      = 4'hA;
    localparam logic [3:0] REG_LBA5      = 4'hB;
    localparam logic [3:0] REG_CONTROL   = 4'hC;

    localparam logic [7:0] CTL_NIEN     = 8'h02;
    localparam logic [7:0] CTL_HOB      = 8'h80;
    localparam logic [7:0] DEV_LBA      = 8'h40;
    localparam logic [7:0] CMD_READ     = 8'h20;
    localparam logic [7:0] CMD_READ_EXT = 8'h24;
    localparam logic [7:0] CMD_WRITE    = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

    // CHS geometry: 63 sectors per track, 16 heads
    localparam logic [9:0]  CHS_TRACK_SPAN = 10'd63;
    // floor(x / 63) = (x * CYL_RECIP) >> 30, exact for 24-bit x
    localparam logic [24:0] CYL_RECIP      = 25'd17043522;
    // floor(r / 63) = (r * HEAD_RECIP) >> 16, exact for r below 1024
    localparam logic [10:0] HEAD_RECIP     = 11'd1041;

    // word sequence of one request; short modes skip from devsel to the tail
    localparam logic [4:0] STEP_DEVSEL = 5'd1;
    localparam logic [4:0] STEP_TAIL   = 5'd14;
    localparam logic [4:0] STEP_LAST   = 5'd18;

    typedef struct packed {
        logic        write_access;
        logic [1:0]  drive_index;
        logic [31:0] block_address;
        logic [7:0]  sector_count;
    } req_t;

    typedef struct packed {
        logic [15:0] port_address;
        logic [3:0]  register_index;
        logic [7:0]  write_data;
        logic        bus_channel;
        logic        last_write;
    } word_t;

    typedef struct packed {
        logic       write_access;
        logic       lba48;
        logic       chan;
        logic [7:0] devsel;
        logic [7:0] count;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } job_t;

    typedef struct packed {
        logic [15:0] pri_cmd;
        logic [15:0] pri_ctl;
        logic [15:0] sec_cmd;
        logic [15:0] sec_ctl;
    } base_cfg_t;

    function automatic logic [3:0] step_register(input logic [4:0] step);
        logic [3:0] r;
        unique case (step) inside
            5'd1:                         r = REG_DEVSEL;
            5'd3:                         r = REG_SECCOUNT1;
            5'd6:                         r = REG_LBA3;
            5'd9:                         r = REG_LBA4;
            5'd12:                        r = REG_LBA5;
            5'd14:                        r = REG_SECCOUNT0;
            5'd15:                        r = REG_LBA0;
            5'd16:                        r = REG_LBA1;
            5'd17:                        r = REG_LBA2;
            5'd18:                        r = REG_COMMAND;
            default:                      r = REG_CONTROL;
        endcase
        return r;
    endfunction

    function automatic logic step_sets_hob(input logic [4:0] step);
        logic h;
        unique case (step) inside
            5'd2, 5'd5, 5'd8, 5'd11: h = 1'b1;
            default:                 h = 1'b0;
        endcase
        return h;
    endfunction

endpackage

// ===== hw/rtl/atci_fifo.sv =====
`timescale 1ns / 1ps
// Short request queue between the classify front and the write sequencer.
module atci_fifo #(
    parameter int WIDTH = $bits(atci_pkg::job_t),
    parameter int DEPTH = atci_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             nonempty,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue pushed while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> nonempty)
        else $error("queue popped while empty");
    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");
endmodule

// ===== hw/rtl/atci_front.sv =====
`timescale 1ns / 1ps
// Request front: accept, pick addressing mode, split CHS geometry, build the job.
module atci_front #(
    parameter int DRIVE_COUNT = atci_pkg::DRIVE_COUNT_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  atci_pkg::req_t         in_word,
    input  logic [DRIVE_COUNT-1:0] channel_mask,
    input  logic [DRIVE_COUNT-1:0] slave_mask,
    input  logic [DRIVE_COUNT-1:0] lba28_mask,
    output logic                   job_valid,
    input  logic                   job_full,
    output atci_pkg::job_t         job_word
);
    import atci_pkg::*;

    typedef enum logic [1:0] {
        MODE_CHS,
        MODE_LBA28,
        MODE_LBA48
    } mode_t;

    logic [DRIVE_SLOTS-1:0] chan_ext, slave_ext, lba28_ext;
    logic                   drive_ok;
    logic                   advance;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    req_t        s1_req_reg, s2_req_reg, s3_req_reg;
    logic        s1_chan_reg, s2_chan_reg, s3_chan_reg;
    logic        s1_slave_reg, s2_slave_reg, s3_slave_reg;
    mode_t       s1_mode_reg, s2_mode_reg, s3_mode_reg;
    logic [18:0] s2_quot_reg, s3_quot_reg;
    logic [9:0]  s3_rem_reg;
    logic [3:0]  s3_head_reg;

    logic [48:0] cyl_prod;
    logic [27:0] cyl_span;
    logic [27:0] rem_full;
    logic [9:0]  rem;
    logic [19:0] head_prod;
    logic [9:0]  sect_full;
    logic [3:0]  head;
    mode_t       mode_in;

    for (genvar i = 0; i < DRIVE_SLOTS; i++)
    begin : g_drive
        if (i < DRIVE_COUNT)
        begin : g_real
            assign chan_ext[i]  = channel_mask[i];
            assign slave_ext[i] = slave_mask[i];
            assign lba28_ext[i] = lba28_mask[i];
        end
        else
        begin : g_absent
            assign chan_ext[i]  = 1'b0;
            assign slave_ext[i] = 1'b0;
            assign lba28_ext[i] = 1'b0;
        end
    end

    // pipeline moves unless the last stage holds a job the queue cannot take
    assign advance   = !(s3_valid_reg && job_full);
    assign in_stall  = !advance;
    assign job_valid = s3_valid_reg;
    // requests for absent drives are taken and dropped
    assign drive_ok  = (4'(in_word.drive_index) < 4'(DRIVE_COUNT));

    always_comb
    begin
        if (in_word.block_address[31:28] != 4'd0)
        begin
            mode_in = MODE_LBA48;
        end
        else if (lba28_ext[in_word.drive_index])
        begin
            mode_in = MODE_LBA28;
        end
        else
        begin
            mode_in = MODE_CHS;
        end
    end

    // cylinder = lba / 1008 = (lba >> 4) / 63
    assign cyl_prod  = 49'(s1_req_reg.block_address[27:4]) * 49'(CYL_RECIP);
    // remainder within the cylinder, then head = rem / 63
    assign cyl_span  = (28'(s2_quot_reg) << 10) - (28'(s2_quot_reg) << 4);
    assign rem_full  = s2_req_reg.block_address[27:0] - cyl_span;
    assign rem       = rem_full[9:0];
    assign head_prod = 20'(rem) * 20'(HEAD_RECIP);
    assign sect_full = s3_rem_reg - ((10'(s3_head_reg) << 6) - 10'(s3_head_reg)) + 10'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid && drive_ok;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_req_reg   <= in_word;
            s1_chan_reg  <= chan_ext[in_word.drive_index];
            s1_slave_reg <= slave_ext[in_word.drive_index];
            s1_mode_reg  <= mode_in;

            s2_req_reg   <= s1_req_reg;
            s2_chan_reg  <= s1_chan_reg;
            s2_slave_reg <= s1_slave_reg;
            s2_mode_reg  <= s1_mode_reg;
            s2_quot_reg  <= cyl_prod[48:30];

            s3_req_reg   <= s2_req_reg;
            s3_chan_reg  <= s2_chan_reg;
            s3_slave_reg <= s2_slave_reg;
            s3_mode_reg  <= s2_mode_reg;
            s3_quot_reg  <= s2_quot_reg;
            s3_rem_reg   <= rem;
            s3_head_reg  <= head_prod[19:16];
        end
    end

    always_comb
    begin
        unique case (s3_mode_reg)
            MODE_LBA48: head = 4'd0;
            MODE_LBA28: head = s3_req_reg.block_address[27:24];
            default:    head = s3_head_reg;
        endcase
        job_word.write_access = s3_req_reg.write_access;
        job_word.lba48        = (s3_mode_reg == MODE_LBA48);
        job_word.chan         = s3_chan_reg;
        job_word.devsel       = ((s3_mode_reg != MODE_CHS) ? DEV_LBA : 8'h00)
                              | {3'b000, s3_slave_reg, head};
        job_word.count        = s3_req_reg.sector_count;
        job_word.b3           = (s3_mode_reg == MODE_LBA48) ?
                                s3_req_reg.block_address[31:24] : 8'h00;
        if (s3_mode_reg == MODE_CHS)
        begin
            job_word.b0 = sect_full[7:0];
            job_word.b1 = s3_quot_reg[7:0];
            job_word.b2 = s3_quot_reg[15:8];
        end
        else
        begin
            job_word.b0 = s3_req_reg.block_address[7:0];
            job_word.b1 = s3_req_reg.block_address[15:8];
            job_word.b2 = s3_req_reg.block_address[23:16];
        end
    end

    a_chs_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_mode_reg == MODE_CHS) |-> (sect_full >= 10'd1 && sect_full <= 10'd63))
        else $error("CHS sector out of range");
    a_stall_holds_job: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && job_full) |=> (s3_valid_reg && $stable(s3_req_reg)))
        else $error("job dropped while queue full");
    a_lba48_mode: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> ((s3_mode_reg == MODE_LBA48) == (s3_req_reg.block_address[31:28] != 4'd0)))
        else $error("LBA48 chosen for wrong address");
endmodule

// ===== hw/rtl/atci_back.sv =====
`timescale 1ns / 1ps
// Write sequencer: walks a job through its task-file writes, one word per cycle unless stalled.
module atci_back (
    input  logic                clk,
    input  logic                rst_n,
    input  atci_pkg::base_cfg_t bases,
    input  logic                job_ready,
    input  atci_pkg::job_t      job_head,
    output logic                job_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output atci_pkg::word_t     out_word
);
    import atci_pkg::*;

    logic        job_valid_reg, job_valid_next;
    job_t        job_reg;
    logic [4:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    word_t       out_reg, out_next;

    logic        advance;
    logic        emit;
    logic        at_last;
    logic        load;
    logic [3:0]  reg_idx;
    logic [3:0]  offset;
    logic [15:0] cmd_base, ctl_base, port;
    logic [7:0]  data;
    logic [7:0]  cmd;

    assign advance  = !out_valid_reg || !out_stall;
    assign emit     = advance && job_valid_reg;
    assign at_last  = (step_reg == STEP_LAST);
    // take the next job as the current one sends its command word
    assign load     = !job_valid_reg || (emit && at_last);
    assign job_pop  = load && job_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    assign reg_idx  = step_register(step_reg);
    assign cmd_base = job_reg.chan ? bases.sec_cmd : bases.pri_cmd;
    assign ctl_base = job_reg.chan ? bases.sec_ctl : bases.pri_ctl;

    always_comb
    begin
        if (reg_idx < REG_SECCOUNT1)
        begin
            offset = reg_idx;
        end
        else if (reg_idx < REG_CONTROL)
        begin
            offset = reg_idx - 4'd6;
        end
        else
        begin
            offset = reg_idx - 4'd10;
        end
        port = ((reg_idx < REG_CONTROL) ? cmd_base : ctl_base) + 16'(offset);

        if (job_reg.lba48)
        begin
            cmd = job_reg.write_access ? CMD_WRITE_EXT : CMD_READ_EXT;
        end
        else
        begin
            cmd = job_reg.write_access ? CMD_WRITE : CMD_READ;
        end

        unique case (reg_idx)
            REG_CONTROL:   data = step_sets_hob(step_reg) ? (CTL_HOB | CTL_NIEN) : CTL_NIEN;
            REG_DEVSEL:    data = job_reg.devsel;
            REG_LBA3:      data = job_reg.b3;
            REG_SECCOUNT0: data = job_reg.count;
            REG_LBA0:      data = job_reg.b0;
            REG_LBA1:      data = job_reg.b1;
            REG_LBA2:      data = job_reg.b2;
            REG_COMMAND:   data = cmd;
            default:       data = 8'h00;
        endcase
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = job_valid_reg;
        end
        if (emit)
        begin
            out_next.port_address   = port;
            out_next.register_index = reg_idx;
            out_next.write_data     = data;
            out_next.bus_channel    = job_reg.chan;
            out_next.last_write     = at_last;
            if (at_last)
            begin
                step_next = '0;
            end
            else if (!job_reg.lba48 && step_reg == STEP_DEVSEL)
            begin
                step_next = STEP_TAIL;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
        if (load)
        begin
            job_valid_next = job_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (job_pop)
        begin
            job_reg <= job_head;
        end
    end

    a_last_is_command: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.last_write) |-> (out_reg.register_index == REG_COMMAND))
        else $error("run ended on a non-command write");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST)
        else $error("sequencer step out of range");
    a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        !job_valid_reg |-> (step_reg == 5'd0))
        else $error("sequencer step left over without a job");
    a_short_skips_hob: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && !job_reg.lba48) |-> (step_reg <= STEP_DEVSEL || step_reg >= STEP_TAIL))
        else $error("short mode entered the high-order section");
endmodule

// ===== hw/rtl/ata_taskfile_command_issuer.sv =====
`timescale 1ns / 1ps
// Top level of the ATA task-file command issuer: config registers, front, queue, sequencer.
//
// Each accepted request becomes its run of task-file byte writes on the out channel, one word
// per cycle while out_stall is low: 7 words for CHS and LBA28 requests, 19 for LBA48 requests
// (address at or above 2^28), the last one being the command write with last_write set. The
// write sequencer sets the sustained pace; a three-stage front (mode pick, cylinder split by
// reciprocal multiply, head and sector split) feeds a QUEUE_DEPTH-entry job queue, so requests
// are taken back to back until that queue fills; the queue then feeds the sequencer's job and
// output registers. Requests naming a drive at or above DRIVE_COUNT are taken and produce no
// words. The user must write configuration only while idle; the block does not enforce it.
module ata_taskfile_command_issuer #(
    parameter int DRIVE_COUNT = atci_pkg::DRIVE_COUNT_DEFAULT,
    parameter int QUEUE_DEPTH = atci_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  atci_pkg::req_t  in_word,
    output logic            out_valid,
    input  logic            out_stall,
    output atci_pkg::word_t out_word,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [15:0]     cfg_data
);
    import atci_pkg::*;

    logic [DRIVE_COUNT-1:0] channel_mask_reg;
    logic [DRIVE_COUNT-1:0] slave_mask_reg;
    logic [DRIVE_COUNT-1:0] lba28_mask_reg;
    base_cfg_t              bases_reg;

    logic job_push, job_full, job_ready, job_pop;
    job_t job_in, job_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_mask_reg  <= DRIVE_COUNT'(CHANNEL_MASK_RESET);
            slave_mask_reg    <= DRIVE_COUNT'(SLAVE_MASK_RESET);
            lba28_mask_reg    <= DRIVE_COUNT'(LBA28_MASK_RESET);
            bases_reg.pri_cmd <= PRI_CMD_BASE_RESET;
            bases_reg.pri_ctl <= PRI_CTL_BASE_RESET;
            bases_reg.sec_cmd <= SEC_CMD_BASE_RESET;
            bases_reg.sec_ctl <= SEC_CTL_BASE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_MASK: channel_mask_reg  <= cfg_data[DRIVE_COUNT-1:0];
                CFG_SLAVE_MASK:   slave_mask_reg    <= cfg_data[DRIVE_COUNT-1:0];
                CFG_LBA28_MASK:   lba28_mask_reg    <= cfg_data[DRIVE_COUNT-1:0];
                CFG_PRI_CMD_BASE: bases_reg.pri_cmd <= cfg_data;
                CFG_PRI_CTL_BASE: bases_reg.pri_ctl <= cfg_data;
                CFG_SEC_CMD_BASE: bases_reg.sec_cmd <= cfg_data;
                CFG_SEC_CTL_BASE: bases_reg.sec_ctl <= cfg_data;
                default: ;
            endcase
        end
    end

    atci_front #(
        .DRIVE_COUNT (DRIVE_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_word      (in_word),
        .channel_mask (channel_mask_reg),
        .slave_mask   (slave_mask_reg),
        .lba28_mask   (lba28_mask_reg),
        .job_valid    (job_push),
        .job_full     (job_full),
        .job_word     (job_in)
    );

    atci_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push && !job_full),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .nonempty  (job_ready),
        .pop_data  (job_head)
    );

    atci_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .bases     (bases_reg),
        .job_ready (job_ready),
        .job_head  (job_head),
        .job_pop   (job_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );
endmodule

// ===== tb/sv/atci_word_checker.sv =====
`timescale 1ns / 1ps
// Checker for the ATA task-file command issuer: predicts and compares every output word.
module atci_word_checker #(
    parameter int DRIVE_COUNT = atci_pkg::DRIVE_COUNT_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_stall,
    input  atci_pkg::req_t  in_word,
    input  logic            out_valid,
    input  logic            out_stall,
    input  atci_pkg::word_t out_word,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    output int              pending_words,
    output int              failures,
    output int              words_checked
);
    import atci_pkg::*;

    typedef enum logic [1:0] {ADDR_CHS, ADDR_LBA28, ADDR_LBA48} addr_mode_t;

    localparam logic [31:0] LBA48_START   = 32'h1000_0000;
    localparam logic [31:0] TRACK_SECTORS = 32'd63;
    localparam logic [31:0] CYL_SECTORS   = 32'd1008;
    // port offsets of the high-order and control register groups
    localparam logic [15:0] HOB_PORT_SHIFT = 16'd6;
    localparam logic [15:0] CTL_PORT_SHIFT = 16'd10;

    logic [3:0]  chan_mask;
    logic [3:0]  slave_mask;
    logic [3:0]  lba_mask;
    logic [15:0] pri_cmd_base;
    logic [15:0] pri_ctl_base;
    logic [15:0] sec_cmd_base;
    logic [15:0] sec_ctl_base;

    word_t expected_words[$];

    initial
    begin
        pending_words = 0;
        failures      = 0;
        words_checked = 0;
    end

    function automatic logic [15:0] port_for(input logic chan, input logic [3:0] reg_num);
        logic [15:0] cmd_base;
        logic [15:0] ctl_base;
        cmd_base = chan ? sec_cmd_base : pri_cmd_base;
        ctl_base = chan ? sec_ctl_base : pri_ctl_base;
        if (reg_num < REG_SECCOUNT1)
            return cmd_base + {12'h0, reg_num};
        else if (reg_num < REG_CONTROL)
            return cmd_base + {12'h0, reg_num} - HOB_PORT_SHIFT;
        else
            return ctl_base + {12'h0, reg_num} - CTL_PORT_SHIFT;
    endfunction

    task automatic push_word(input logic chan, input logic [3:0] reg_num,
                             input logic [7:0] data, input logic last);
        word_t w;
        w.port_address   = port_for(chan, reg_num);
        w.register_index = reg_num;
        w.write_data     = data;
        w.bus_channel    = chan;
        w.last_write     = last;
        expected_words.push_back(w);
    endtask

    // bracket a high-order register write with HOB set and cleared
    task automatic push_hob_word(input logic chan, input logic [3:0] reg_num,
                                 input logic [7:0] data);
        push_word(chan, REG_CONTROL, CTL_HOB | CTL_NIEN, 1'b0);
        push_word(chan, reg_num, data, 1'b0);
        push_word(chan, REG_CONTROL, CTL_NIEN, 1'b0);
    endtask

    task automatic predict_request(input req_t r);
        logic        chan;
        logic        slave;
        addr_mode_t  mode;
        logic [31:0] lba;
        logic [31:0] sect_off;
        logic [31:0] track_base;
        logic [31:0] cyl;
        logic [31:0] head;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  devsel;
        logic [7:0]  opcode;
        if (int'(r.drive_index) >= DRIVE_COUNT)
            return;
        chan  = chan_mask[r.drive_index];
        slave = slave_mask[r.drive_index];
        lba   = r.block_address;
        b3    = 8'h00;
        if (lba >= LBA48_START)
        begin
            mode = ADDR_LBA48;
            b0   = lba[7:0];
            b1   = lba[15:8];
            b2   = lba[23:16];
            b3   = lba[31:24];
            head = 0;
        end
        else if (lba_mask[r.drive_index])
        begin
            mode = ADDR_LBA28;
            b0   = lba[7:0];
            b1   = lba[15:8];
            b2   = lba[23:16];
            head = {28'h0, lba[27:24]};
        end
        else
        begin
            mode       = ADDR_CHS;
            sect_off   = lba % TRACK_SECTORS;
            track_base = lba - sect_off;
            cyl        = track_base / CYL_SECTORS;
            head       = (track_base % CYL_SECTORS) / TRACK_SECTORS;
            b0         = 8'(sect_off + 1);
            b1         = cyl[7:0];
            b2         = cyl[15:8];
        end
        devsel = ((mode != ADDR_CHS) ? DEV_LBA : 8'h00) | {3'b000, slave, head[3:0]};
        if (mode == ADDR_LBA48)
            opcode = r.write_access ? CMD_WRITE_EXT : CMD_READ_EXT;
        else
            opcode = r.write_access ? CMD_WRITE : CMD_READ;

        push_word(chan, REG_CONTROL, CTL_NIEN, 1'b0);
        push_word(chan, REG_DEVSEL, devsel, 1'b0);
        if (mode == ADDR_LBA48)
        begin
            push_hob_word(chan, REG_SECCOUNT1, 8'h00);
            push_hob_word(chan, REG_LBA3, b3);
            push_hob_word(chan, REG_LBA4, 8'h00);
            push_hob_word(chan, REG_LBA5, 8'h00);
        end
        push_word(chan, REG_SECCOUNT0, r.sector_count, 1'b0);
        push_word(chan, REG_LBA0, b0, 1'b0);
        push_word(chan, REG_LBA1, b1, 1'b0);
        push_word(chan, REG_LBA2, b2, 1'b0);
        push_word(chan, REG_COMMAND, opcode, 1'b1);
    endtask

    task automatic compare_field(input string name, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_mask    = CHANNEL_MASK_RESET;
            slave_mask   = SLAVE_MASK_RESET;
            lba_mask     = LBA28_MASK_RESET;
            pri_cmd_base = PRI_CMD_BASE_RESET;
            pri_ctl_base = PRI_CTL_BASE_RESET;
            sec_cmd_base = SEC_CMD_BASE_RESET;
            sec_ctl_base = SEC_CTL_BASE_RESET;
            expected_words.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHANNEL_MASK: chan_mask    = cfg_data[3:0];
                    CFG_SLAVE_MASK:   slave_mask   = cfg_data[3:0];
                    CFG_LBA28_MASK:   lba_mask     = cfg_data[3:0];
                    CFG_PRI_CMD_BASE: pri_cmd_base = cfg_data;
                    CFG_PRI_CTL_BASE: pri_ctl_base = cfg_data;
                    CFG_SEC_CMD_BASE: sec_cmd_base = cfg_data;
                    CFG_SEC_CTL_BASE: sec_ctl_base = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_request(in_word);
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected task-file write: port %0h reg %0h data %0h",
                           out_word.port_address, out_word.register_index,
                           out_word.write_data);
                    failures++;
                end
                else
                begin
                    word_t w;
                    w = expected_words.pop_front();
                    compare_field("port_address", w.port_address, out_word.port_address);
                    compare_field("register_index", 16'(w.register_index),
                                  16'(out_word.register_index));
                    compare_field("write_data", 16'(w.write_data), 16'(out_word.write_data));
                    compare_field("bus_channel", 16'(w.bus_channel), 16'(out_word.bus_channel));
                    compare_field("last_write", 16'(w.last_write), 16'(out_word.last_write));
                    words_checked++;
                end
            end
        end
        pending_words = expected_words.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the command issuer testbench: clock, reset, request and config stimulus, verdict.
module testbench;
    import atci_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          SETTLE_TIME  = 20;
    localparam logic [31:0] LBA48_START  = 32'h1000_0000;
    // index past the register list; writes there must be ignored
    localparam logic [2:0]  CFG_UNUSED   = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    req_t        in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    word_t       out_word;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int pending_words;
    int check_failures;
    int words_checked;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int requests_sent = 0;
    int wide_requests = 0;
    int settings_applied = 0;

    always #1 clk = ~clk;

    ata_taskfile_command_issuer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    atci_word_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_word       (in_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_word      (out_word),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending_words (pending_words),
        .failures      (check_failures),
        .words_checked (words_checked)
    );

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d words outstanding", pending_words);
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic put_request(input logic wr, input logic [1:0] drv,
                               input logic [31:0] lba, input logic [7:0] cnt);
        req_t r;
        r.write_access  = wr;
        r.drive_index   = drv;
        r.block_address = lba;
        r.sector_count  = cnt;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= r;
        @(posedge clk);
        // hold the word until the block takes it
        while (in_stall)
            @(posedge clk);
        requests_sent++;
        if (lba >= LBA48_START)
            wide_requests++;
    endtask

    task automatic run_random(input int n);
        logic [31:0] lba;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0: lba = $urandom_range(32'h0000_FFFF);
                1: lba = $urandom_range(32'h0FFF_FFFF);
                2: lba = $urandom_range(32'hFFFF_FFFF, LBA48_START);
                default: lba = $urandom;
            endcase
            put_request(1'($urandom_range(1)), 2'($urandom_range(3)), lba,
                        8'($urandom_range(255)));
        end
    endtask

    // stop sending and wait for every predicted word, then let the pipe settle
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (SETTLE_TIME) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [3:0] ch, input logic [3:0] sl,
                                 input logic [3:0] lb, input logic [15:0] pcmd,
                                 input logic [15:0] pctl, input logic [15:0] scmd,
                                 input logic [15:0] sctl);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CHANNEL_MASK;
        cfg_data  <= {12'h000, ch};
        @(posedge clk);
        cfg_index <= CFG_SLAVE_MASK;
        cfg_data  <= {12'h000, sl};
        @(posedge clk);
        cfg_index <= CFG_LBA28_MASK;
        cfg_data  <= {12'h000, lb};
        @(posedge clk);
        cfg_index <= CFG_PRI_CMD_BASE;
        cfg_data  <= pcmd;
        @(posedge clk);
        cfg_index <= CFG_PRI_CTL_BASE;
        cfg_data  <= pctl;
        @(posedge clk);
        cfg_index <= CFG_SEC_CMD_BASE;
        cfg_data  <= scmd;
        @(posedge clk);
        cfg_index <= CFG_SEC_CTL_BASE;
        cfg_data  <= sctl;
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 16'($urandom_range(16'hFFFF));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;
        recv_idle_pct = 81;
        // drives 1 and 3 fall back to CHS, the rest keep reset values
        apply_setting(CHANNEL_MASK_RESET, SLAVE_MASK_RESET, 4'b0101, PRI_CMD_BASE_RESET,
                      PRI_CTL_BASE_RESET, SEC_CMD_BASE_RESET, SEC_CTL_BASE_RESET);

        put_request(1'b0, 2'd0, 32'h0000_0000, 8'd0);
        put_request(1'b1, 2'd0, 32'h0FFF_FFFF, 8'd255);
        put_request(1'b0, 2'd2, 32'h0ABC_DEF1, 8'd1);
        put_request(1'b1, 2'd1, 32'h0000_0000, 8'd0);
        put_request(1'b0, 2'd1, 32'd62, 8'd3);
        put_request(1'b1, 2'd1, 32'd63, 8'd4);
        put_request(1'b0, 2'd3, 32'd1007, 8'd5);
        put_request(1'b1, 2'd3, 32'd1008, 8'd6);
        // cylinder wraps past 16 bits
        put_request(1'b0, 2'd1, 32'd66060288, 8'd9);
        put_request(1'b0, 2'd1, 32'h0FFF_FFFF, 8'd255);
        put_request(1'b1, 2'd3, 32'h00FF_FFFF, 8'd128);
        put_request(1'b0, 2'd0, LBA48_START, 8'd7);
        put_request(1'b1, 2'd1, LBA48_START, 8'd8);
        put_request(1'b0, 2'd2, 32'hFFFF_FFFF, 8'd255);
        put_request(1'b1, 2'd3, 32'hFFFF_FFFF, 8'd0);
        put_request(1'b1, 2'd2, 32'h8000_0000, 8'h55);
        put_request(1'b0, 2'd3, 32'h7FFF_FFFF, 8'hAA);
        run_random(50);
        drain();

        apply_setting(4'h0, 4'h0, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_random(50);
        drain();

        send_idle_pct = 81;
        recv_idle_pct = 7;
        // all ones but the secondary control base: secondary slaves everywhere, bases wrap at 16 bits
        apply_setting(4'hF, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFA);
        run_random(25);
        drain();
        run_random(25);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)),
                      16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                      16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
        run_random(50);
        drain();

        $display("covered %0d requests (%0d in LBA48 range) under %0d register settings,",
                 requests_sent, wide_requests, settings_applied);
        $display("%0d task-file writes checked, %0d mismatches", words_checked,
                 check_failures);
        if (check_failures == 0 && pending_words == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
